@@ design/rsp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rsp_pkg
// Shared constants and types of the Reed-Solomon systematic parity encoder.
// ----------------------------------------------------------------------------
package rsp_pkg;

  localparam int DEG_DEFAULT        = 8;
  localparam int PARITY_MAX_DEFAULT = 16;

  localparam int SYM_W        = 8;
  localparam int FIELD_POLY_W = 9;
  localparam int NUM_PARITY_W = 5;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 9;

  localparam logic [CFG_IDX_W-1:0] REG_FIELD_POLY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_PARITY = 1'd1;

  localparam logic [FIELD_POLY_W-1:0] FIELD_POLY_RST = 9'd285;
  localparam logic [NUM_PARITY_W-1:0] NUM_PARITY_RST = 5'd2;

  // control broadcast to every cell
  typedef struct packed {
    logic build_clr;
    logic build_step;
    logic load_act;
    logic lfsr_step;
    logic shift_out;
  } cell_ctrl_t;

  // one result transfer
  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             parity;
    logic             eoc;
  } res_t;

endpackage : rsp_pkg
`default_nettype wire

@@ design/rs_systematic_parity_encoder_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rs_systematic_parity_encoder_unit
// Systematic Reed-Solomon encoder over GF(2^DEG) built as a chain of cells.
// ----------------------------------------------------------------------------
// Information symbols are taken one per cycle while the output stage has
// room and no parity is pending, and are echoed; the remainder cells all
// update in the same cycle. After the symbol marked tlast, the n parity
// symbols (tuser high, tlast on the final one) follow one per cycle while
// the output stage has room, and the input is held off until they are out.
// After reset and after every configuration write the generator is rebuilt
// in the cells; a new codeword does not start before that ends.
// A codeword in progress keeps the generator and n it started with.
// ----------------------------------------------------------------------------
module rs_systematic_parity_encoder_unit
  import rsp_pkg::*;
#(
  parameter int DEG        = DEG_DEFAULT,
  parameter int PARITY_MAX = PARITY_MAX_DEFAULT
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                    s_tvalid,
  output logic                         s_tready,
  input  wire logic [SYM_W-1:0]        s_tdata,   // data_symbol
  input  wire logic                    s_tlast,   // last
  output logic                         m_tvalid,
  input  wire logic                    m_tready,
  output logic      [SYM_W-1:0]        m_tdata,   // out_symbol
  output logic                         m_tuser,   // is_parity
  output logic                         m_tlast    // end_of_codeword
);

  localparam int NPW = $clog2(PARITY_MAX + 1);
  localparam int CW  = (DEG < SYM_W) ? DEG : SYM_W;
  localparam int PW  = (DEG < FIELD_POLY_W) ? DEG : FIELD_POLY_W;

  typedef enum logic [1:0] {
    B_START,
    B_RUN,
    B_DONE
  } build_e;

  build_e                  bstate_q;
  logic [FIELD_POLY_W-1:0] field_poly_q;
  logic [NUM_PARITY_W-1:0] num_parity_q;
  logic [DEG-1:0]          root_q;
  logic [NPW-1:0]          step_q;
  logic                    busy_q;
  logic                    par_q;
  logic [NPW-1:0]          act_np_q;
  logic [NPW-1:0]          par_cnt_q;

  logic [DEG-1:0] red;
  logic [DEG-1:0] root_d;
  logic [DEG-1:0] d_sym;
  logic [DEG-1:0] fb;
  logic [NPW-1:0] np_eff;
  logic [NPW-1:0] np_next;
  logic           room;
  logic           fire_in;
  logic           start_cw;
  logic           emit_par;
  logic           emit;
  res_t           emit_data;
  res_t           m_data;
  cell_ctrl_t     ctrl;

  logic [DEG-1:0] rem_w [PARITY_MAX+1];
  logic [DEG-1:0] g_w   [PARITY_MAX+1];

  always_comb begin
    red    = DEG'(field_poly_q[PW-1:0]);
    root_d = root_q[DEG-1] ? ({root_q[DEG-2:0], 1'b0} ^ red) : {root_q[DEG-2:0], 1'b0};
    d_sym  = DEG'(s_tdata[CW-1:0]);
    fb     = d_sym ^ rem_w[0];

    if (num_parity_q == '0) begin
      np_eff = NPW'(1);
    end else if (int'(num_parity_q) > PARITY_MAX) begin
      np_eff = NPW'(PARITY_MAX);
    end else begin
      np_eff = NPW'(num_parity_q);
    end

    s_tready = room && !par_q && (busy_q || (bstate_q == B_DONE));
    fire_in  = s_tvalid && s_tready;
    start_cw = fire_in && !busy_q;
    emit_par = par_q && room;
    emit     = fire_in || emit_par;
    np_next  = start_cw ? np_eff : act_np_q;

    ctrl.build_clr  = (bstate_q == B_START);
    ctrl.build_step = (bstate_q == B_RUN) && (step_q < np_eff);
    ctrl.load_act   = start_cw;
    ctrl.lfsr_step  = fire_in;
    ctrl.shift_out  = emit_par;

    if (fire_in) begin
      emit_data.sym    = SYM_W'(d_sym[CW-1:0]);
      emit_data.parity = 1'b0;
      emit_data.eoc    = 1'b0;
    end else begin
      emit_data.sym    = SYM_W'(rem_w[0][CW-1:0]);
      emit_data.parity = 1'b1;
      emit_data.eoc    = (par_cnt_q == NPW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bstate_q     <= B_START;
      field_poly_q <= FIELD_POLY_RST;
      num_parity_q <= NUM_PARITY_RST;
      root_q       <= '0;
      step_q       <= '0;
      busy_q       <= 1'b0;
      par_q        <= 1'b0;
      act_np_q     <= '0;
      par_cnt_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_FIELD_POLY: field_poly_q <= cfg_data_i[FIELD_POLY_W-1:0];
          REG_NUM_PARITY: num_parity_q <= cfg_data_i[NUM_PARITY_W-1:0];
          default: ;
        endcase
        bstate_q <= B_START;
      end else begin
        case (bstate_q)
          B_START: begin
            root_q   <= DEG'(2);
            step_q   <= '0;
            bstate_q <= B_RUN;
          end
          B_RUN: begin
            if (step_q < np_eff) begin
              step_q <= step_q + NPW'(1);
              root_q <= root_d;
            end else begin
              bstate_q <= B_DONE;
            end
          end
          B_DONE: ;
          default: bstate_q <= B_START;
        endcase
      end

      if (start_cw) act_np_q <= np_eff;
      if (fire_in) begin
        if (s_tlast) begin
          busy_q    <= 1'b0;
          par_q     <= 1'b1;
          par_cnt_q <= np_next;
        end else begin
          busy_q <= 1'b1;
        end
      end
      if (emit_par) begin
        par_cnt_q <= par_cnt_q - NPW'(1);
        if (par_cnt_q == NPW'(1)) par_q <= 1'b0;
      end
    end
  end

  assign rem_w[PARITY_MAX] = '0;
  assign g_w[0]            = DEG'(1);

  for (genvar j = 0; j < PARITY_MAX; j++) begin : g_cell
    rsp_cell #(
      .DEG (DEG)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .red_i  (red),
      .fb_i   (fb),
      .root_i (root_q),
      .rem_i  (rem_w[j+1]),
      .g_i    (g_w[j]),
      .rem_o  (rem_w[j]),
      .g_o    (g_w[j+1])
    );
  end

  rsp_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (emit),
    .in_data_i   (emit_data),
    .room_o      (room),
    .out_valid_o (m_tvalid),
    .out_ready_i (m_tready),
    .out_data_o  (m_data)
  );

  assign m_tdata = m_data.sym;
  assign m_tuser = m_data.parity;
  assign m_tlast = m_data.eoc;

endmodule : rs_systematic_parity_encoder_unit
`default_nettype wire

@@ design/rsp_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rsp_cell
// One stage of the encoder chain: a remainder symbol, the active generator
// coefficient and the generator coefficient under construction.
// ----------------------------------------------------------------------------
module rsp_cell
  import rsp_pkg::*;
#(
  parameter int DEG = DEG_DEFAULT
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire cell_ctrl_t     ctrl_i,
  input  wire logic [DEG-1:0] red_i,
  input  wire logic [DEG-1:0] fb_i,
  input  wire logic [DEG-1:0] root_i,
  input  wire logic [DEG-1:0] rem_i,
  input  wire logic [DEG-1:0] g_i,
  output logic      [DEG-1:0] rem_o,
  output logic      [DEG-1:0] g_o
);

  function automatic logic [DEG-1:0] gf_mul(input logic [DEG-1:0] a,
                                            input logic [DEG-1:0] b,
                                            input logic [DEG-1:0] red);
    logic [DEG-1:0] r;
    logic [DEG-1:0] x;
    r = '0;
    x = a;
    for (int i = 0; i < DEG; i++) begin
      if (b[i]) r = r ^ x;
      x = x[DEG-1] ? ({x[DEG-2:0], 1'b0} ^ red) : {x[DEG-2:0], 1'b0};
    end
    return r;
  endfunction

  logic [DEG-1:0] rem_q, rem_d;
  logic [DEG-1:0] gb_q, gb_d;
  logic [DEG-1:0] coef_q, coef_d;
  logic [DEG-1:0] coef_use;

  always_comb begin
    coef_use = ctrl_i.load_act ? gb_q : coef_q;
    coef_d   = ctrl_i.load_act ? gb_q : coef_q;

    gb_d = gb_q;
    if (ctrl_i.build_clr) begin
      gb_d = '0;
    end else if (ctrl_i.build_step) begin
      gb_d = gb_q ^ gf_mul(g_i, root_i, red_i);
    end

    rem_d = rem_q;
    if (ctrl_i.lfsr_step) begin
      rem_d = rem_i ^ gf_mul(fb_i, coef_use, red_i);
    end else if (ctrl_i.shift_out) begin
      rem_d = rem_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    gb_q   <= gb_d;
    coef_q <= coef_d;
  end

  assign rem_o = rem_q;
  assign g_o   = gb_q;

endmodule : rsp_cell
`default_nettype wire

@@ design/rsp_skid.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// rsp_skid
// Two-entry output stage: result register plus skid register.
// ----------------------------------------------------------------------------
module rsp_skid
  import rsp_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire res_t in_data_i,
  output logic      room_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output res_t      out_data_o
);

  logic out_valid_q, out_valid_d;
  logic skid_valid_q, skid_valid_d;
  res_t out_q, out_d;
  res_t skid_q, skid_d;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = in_valid_i;
        out_d       = in_data_i;
      end
    end else if (in_valid_i) begin
      skid_valid_d = 1'b1;
      skid_d       = in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign room_o      = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule : rsp_skid
`default_nettype wire

@@ tb/sv/rs_systematic_parity_encoder_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rs_systematic_parity_encoder_unit_tb
// Self-checking bench for the systematic Reed-Solomon parity encoder.
// ----------------------------------------------------------------------------
// A directed table covers extreme symbols, every num_parity clamp, odd and
// non-primitive field polynomials and a num_parity write inside an open
// codeword. Random codewords follow under random config. Each accepted
// symbol is run through a local GF(2^8) LFSR divider. Every output transfer
// is checked against the oldest expected symbol. Both stream sides stall at
// random.
// ----------------------------------------------------------------------------
module rs_systematic_parity_encoder_unit_tb;
  import rsp_pkg::*;

  localparam int PMAX           = PARITY_MAX_DEFAULT;
  localparam int RANDOM_ITEMS   = 310;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_DIR          = 28;

  localparam logic [FIELD_POLY_W-1:0] PRIM_POLYS [8] = '{
    9'h11D, 9'h12B, 9'h12D, 9'h14D, 9'h15F, 9'h163, 9'h165, 9'h169
  };

  typedef enum logic {ROW_SYM, ROW_CFG} row_kind_e;

  typedef struct packed {
    logic [1:0]       n;
    logic [SYM_W-1:0] p0;
    logic [SYM_W-1:0] p1;
  } known_par_t;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic [SYM_W-1:0]      data;
    logic                  last;
    known_par_t            known;
  } dir_row_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [SYM_W-1:0]      s_tdata;   // data_symbol
  logic                  s_tlast;   // last
  logic                  m_tvalid;
  logic                  m_tready;
  logic [SYM_W-1:0]      m_tdata;   // out_symbol
  logic                  m_tuser;   // is_parity
  logic                  m_tlast;   // end_of_codeword

  // encoder state mirrored by the bench
  logic [FIELD_POLY_W-1:0] cfg_poly;
  logic [NUM_PARITY_W-1:0] cfg_np;
  logic [SYM_W-1:0]        gen_coef  [PMAX];
  logic [SYM_W-1:0]        rem_cells [PMAX];
  bit                      cw_open;
  int                      act_np;

  res_t       expected_syms [$];
  known_par_t known_parity_q [$];

  int errors;
  int n_symbols;
  int n_parity_syms;
  int n_codewords;
  int n_cfg_writes;
  int stall_cycles;

  rs_systematic_parity_encoder_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [SYM_W-1:0] gf_mult(input logic [SYM_W-1:0] a,
                                               input logic [SYM_W-1:0] b,
                                               input logic [FIELD_POLY_W-1:0] poly);
    logic [SYM_W:0]   sh;
    logic [SYM_W-1:0] acc;
    sh  = {1'b0, a};
    acc = '0;
    for (int i = 0; i < SYM_W; i++) begin
      if (b[i]) acc ^= sh[SYM_W-1:0];
      sh = sh << 1;
      if (sh[SYM_W]) sh ^= {1'b1, poly[SYM_W-1:0]};
    end
    return acc;
  endfunction

  // g(x) = (x + a^1)...(x + a^n), coefficients below the leading one
  function automatic void rebuild_generator();
    logic [SYM_W-1:0] g [PMAX+1];
    logic [SYM_W-1:0] root;
    if (cfg_np == 0) act_np = 1;
    else if (cfg_np > PMAX) act_np = PMAX;
    else act_np = int'(cfg_np);
    for (int k = 0; k <= PMAX; k++) g[k] = '0;
    g[0] = 8'd1;
    root = 8'd1;
    for (int i = 1; i <= act_np; i++) begin
      root = gf_mult(root, 8'd2, cfg_poly);
      for (int k = i; k >= 1; k--) g[k] ^= gf_mult(g[k-1], root, cfg_poly);
    end
    for (int k = 0; k < PMAX; k++) gen_coef[k] = (k < act_np) ? g[k+1] : '0;
  endfunction

  function automatic void rs_encode_symbol(input logic [SYM_W-1:0] d, input logic l,
                                           input known_par_t kp);
    logic [SYM_W-1:0] fb;
    res_t             r;
    if (!cw_open) begin
      rebuild_generator();
      for (int j = 0; j < PMAX; j++) rem_cells[j] = '0;
      cw_open = 1'b1;
    end
    fb = d ^ rem_cells[0];
    for (int j = 0; j < act_np - 1; j++)
      rem_cells[j] = rem_cells[j+1] ^ gf_mult(fb, gen_coef[j], cfg_poly);
    rem_cells[act_np-1] = gf_mult(fb, gen_coef[act_np-1], cfg_poly);
    r.sym    = d;
    r.parity = 1'b0;
    r.eoc    = 1'b0;
    expected_syms = {expected_syms, r};
    if (l) begin
      for (int j = 0; j < act_np; j++) begin
        r.sym = rem_cells[j];
        if (j < kp.n) r.sym = (j == 0) ? kp.p0 : kp.p1;
        r.parity = 1'b1;
        r.eoc    = (j == act_np - 1);
        expected_syms = {expected_syms, r};
      end
      for (int j = 0; j < PMAX; j++) rem_cells[j] = '0;
      cw_open = 1'b0;
    end
  endfunction

  function automatic dir_row_t sym_row(input logic [SYM_W-1:0] d, input logic l,
                                       input logic [1:0] n, input logic [SYM_W-1:0] p0,
                                       input logic [SYM_W-1:0] p1);
    dir_row_t row;
    row         = '0;
    row.kind    = ROW_SYM;
    row.data    = d;
    row.last    = l;
    row.known.n = n;
    row.known.p0 = p0;
    row.known.p1 = p1;
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] val);
    dir_row_t row;
    row      = '0;
    row.kind = ROW_CFG;
    row.idx  = idx;
    row.val  = val;
    return row;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_num_parity();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return CFG_DATA_W'(PMAX);
    if (r == 2) return CFG_DATA_W'($urandom_range(PMAX + 1, 31));
    return CFG_DATA_W'($urandom_range(1, 8));
  endfunction

  function automatic logic [SYM_W-1:0] pick_symbol();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return SYM_W'($urandom_range(0, 255));
  endfunction

  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_syms.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    if (idx == REG_FIELD_POLY) cfg_poly = val[FIELD_POLY_W-1:0];
    else cfg_np = val[NUM_PARITY_W-1:0];
    n_cfg_writes++;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_symbol(input logic [SYM_W-1:0] d, input logic l,
                             input known_par_t kp, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    known_parity_q = {known_parity_q, kp};
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tlast  <= l;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  // input acceptance feeds the predictor first, then the output is checked
  always @(posedge clk_i) begin : monitor
    bit         moved;
    res_t       want;
    known_par_t kp;
    moved = 1'b0;
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        moved = 1'b1;
        kp = known_parity_q.pop_front();
        rs_encode_symbol(s_tdata, s_tlast, kp);
        n_symbols++;
      end
      if (m_tvalid && m_tready) begin
        moved = 1'b1;
        if (m_tuser) n_parity_syms++;
        if (m_tlast) n_codewords++;
        if (expected_syms.size() == 0) begin
          errors++;
          $error("unexpected transfer: out_symbol %0h is_parity %0b end_of_codeword %0b",
                 m_tdata, m_tuser, m_tlast);
        end else begin
          want = expected_syms.pop_front();
          if (m_tdata !== want.sym) begin
            errors++;
            $error("out_symbol: expected %0h, actual %0h", want.sym, m_tdata);
          end
          if (m_tuser !== want.parity) begin
            errors++;
            $error("is_parity: expected %0b, actual %0b", want.parity, m_tuser);
          end
          if (m_tlast !== want.eoc) begin
            errors++;
            $error("end_of_codeword: expected %0b, actual %0b", want.eoc, m_tlast);
          end
        end
      end
    end
    if (moved) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d symbols still expected",
               stall_cycles, expected_syms.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : sink
    int hi;
    int lo;
    m_tready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      hi = ($urandom_range(0, 6) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 6);
      m_tready <= 1'b1;
      repeat (hi) @(posedge clk_i);
      lo = pick_gap();
      if (lo > 0) begin
        m_tready <= 1'b0;
        repeat (lo) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    dir_row_t dir_rows [N_DIR];
    int       random_items;
    int       cw_len;
    bit       no_gap;
    bit       first_phase;
    errors        = 0;
    n_symbols     = 0;
    n_parity_syms = 0;
    n_codewords   = 0;
    n_cfg_writes  = 0;
    stall_cycles  = 0;
    cfg_poly      = FIELD_POLY_RST;
    cfg_np        = NUM_PARITY_RST;
    cw_open       = 1'b0;
    act_np        = 1;
    for (int j = 0; j < PMAX; j++) begin
      gen_coef[j]  = '0;
      rem_cells[j] = '0;
    end
    rst_ni     <= 1'b0;
    cfg_we_i   <= 1'b0;
    cfg_idx_i  <= '0;
    cfg_data_i <= '0;
    s_tvalid   <= 1'b0;
    s_tdata    <= '0;
    s_tlast    <= 1'b0;

    // known parities: n=2 over 0x11D gives g = x^2 + 6x + 8; n=1 gives x + 2
    dir_rows = '{
      sym_row(8'h00, 1'b1, 2'd2, 8'h00, 8'h00),
      sym_row(8'h01, 1'b1, 2'd2, 8'h06, 8'h08),
      sym_row(8'hFF, 1'b0, 2'd0, 8'h00, 8'h00),
      sym_row(8'h80, 1'b0, 2'd0, 8'h00, 8'h00),
      sym_row(8'h55, 1'b0, 2'd0, 8'h00, 8'h00),
      sym_row(8'hAA, 1'b1, 2'd0, 8'h00, 8'h00),
      cfg_row(REG_NUM_PARITY, 9'd16),
      sym_row(8'hFF, 1'b0, 2'd0, 8'h00, 8'h00),
      sym_row(8'h01, 1'b1, 2'd0, 8'h00, 8'h00),
      cfg_row(REG_NUM_PARITY, 9'd0),
      sym_row(8'h01, 1'b1, 2'd1, 8'h02, 8'h00),
      cfg_row(REG_NUM_PARITY, 9'd31),
      sym_row(8'h12, 1'b1, 2'd0, 8'h00, 8'h00),
      cfg_row(REG_FIELD_POLY, 9'd256),
      cfg_row(REG_NUM_PARITY, 9'd3),
      sym_row(8'hC3, 1'b0, 2'd0, 8'h00, 8'h00),
      sym_row(8'h3C, 1'b1, 2'd0, 8'h00, 8'h00),
      cfg_row(REG_FIELD_POLY, 9'd511),
      sym_row(8'hE7, 1'b0, 2'd0, 8'h00, 8'h00),
      sym_row(8'h18, 1'b1, 2'd0, 8'h00, 8'h00),
      cfg_row(REG_FIELD_POLY, 9'd0),
      sym_row(8'h07, 1'b1, 2'd0, 8'h00, 8'h00),
      cfg_row(REG_FIELD_POLY, CFG_DATA_W'(FIELD_POLY_RST)),
      cfg_row(REG_NUM_PARITY, 9'd1),
      sym_row(8'h10, 1'b0, 2'd0, 8'h00, 8'h00),
      // write inside the open codeword, n stays 1 until it closes
      cfg_row(REG_NUM_PARITY, 9'd5),
      sym_row(8'h20, 1'b1, 2'd0, 8'h00, 8'h00),
      sym_row(8'h30, 1'b1, 2'd0, 8'h00, 8'h00)
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        wait_quiet();
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_symbol(dir_rows[i].data, dir_rows[i].last, dir_rows[i].known, 1'b0);
      end
    end

    random_items = 0;
    first_phase  = 1'b1;
    while (random_items < RANDOM_ITEMS) begin
      if (first_phase || $urandom_range(0, 9) < 3) begin
        wait_quiet();
        case ($urandom_range(0, 3))
          0, 1: write_reg(REG_FIELD_POLY, CFG_DATA_W'(PRIM_POLYS[$urandom_range(0, 7)]));
          2:    write_reg(REG_FIELD_POLY, CFG_DATA_W'($urandom_range(256, 511)));
          default: write_reg(REG_FIELD_POLY, CFG_DATA_W'($urandom_range(0, 511)));
        endcase
        write_reg(REG_NUM_PARITY, pick_num_parity());
        first_phase = 1'b0;
      end
      cw_len = ($urandom_range(0, 19) < 17) ? $urandom_range(1, 8) : $urandom_range(9, 40);
      if (cw_len > RANDOM_ITEMS - random_items) cw_len = RANDOM_ITEMS - random_items;
      no_gap = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < cw_len; k++) begin
        if (k > 0 && $urandom_range(0, 49) == 0) begin
          wait_quiet();
          write_reg(REG_NUM_PARITY, pick_num_parity());
        end
        send_symbol(pick_symbol(), k == cw_len - 1, '0, no_gap);
        random_items++;
      end
    end

    wait_quiet();
    $display("Encoded %0d codewords: %0d information symbols in, %0d parity symbols out",
             n_codewords, n_symbols, n_parity_syms);
    $display("%0d register writes across field polynomials and parity counts, %0d mismatches",
             n_cfg_writes, errors);
    if (errors == 0 && expected_syms.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/rsp_pkg.sv
design/rsp_cell.sv
design/rsp_skid.sv
design/rs_systematic_parity_encoder_unit.sv
tb/sv/rs_systematic_parity_encoder_unit_tb.sv
